[rtl/core/fqs_pkg.sv]
`timescale 1ns / 1ps

package fqs_pkg;

    localparam int DEPTH  = 8;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_SEARCH  = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [1:0] STATUS_MISSING = 2'd3;

    typedef logic [ADDR_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  count_t;

    function automatic slot_t next_slot(input slot_t slot);
        slot_t result;
        if (slot == slot_t'(DEPTH - 1)) begin
            result = '0;
        end else begin
            result = slot + slot_t'(1);
        end
        return result;
    endfunction

endpackage

[rtl/core/fqs_ram.sv]
`timescale 1ns / 1ps

module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/fifo_queue_with_search.sv]
`timescale 1ns / 1ps
// Each accepted beat yields one result beat: enqueue and any rejected operation go
// straight to the result state, a dequeue reads the head entry in S_READ first, and a
// search scans held entries from the head in S_SEARCH until one matches or none is left.
// Throughput: one beat at a time; the next beat is taken once the result is registered.
// The search loop reads one entry per cycle through the single RAM read port.
// Reset (aresetn low, synchronous) empties the queue; stored entries are left undefined.

module fifo_queue_with_search
    import fqs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data[31:0], position[34:32], occupancy[38:35], zero
    output logic [1:0]  m_tuser    // status[1:0]
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_RESULT
    } state_t;

    state_t             state_reg, state_next;
    slot_t              head_reg, head_next;
    slot_t              tail_reg, tail_next;
    count_t             count_reg, count_next;
    slot_t              scan_reg, scan_next;
    slot_t              offset_reg, offset_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [DATA_W-1:0]  res_data_reg, res_data_next;
    slot_t              res_pos_reg, res_pos_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [39:0]        m_tdata_reg, m_tdata_next;
    logic [1:0]         m_tuser_reg, m_tuser_next;

    logic               ram_we;
    slot_t              ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;
    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic               match;
    logic               last_offset;
    logic [ADDR_W+2:0]  pos_ext;
    logic [CNT_W+3:0]   occ_ext;

    fqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready    = (state_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign is_full     = (count_reg == count_t'(DEPTH));
    assign is_empty    = (count_reg == '0);
    assign match       = (ram_rdata == value_reg);
    assign last_offset = ((count_t'(offset_reg) + count_t'(1)) == count_reg);
    assign ram_raddr   = (state_reg == S_IDLE) ? head_reg : scan_reg;
    assign ram_we      = accept && (s_tuser == OP_ENQUEUE) && !is_full;
    assign pos_ext     = {3'b000, res_pos_reg};
    assign occ_ext     = {4'b0000, count_reg};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        offset_next     = offset_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_pos_next    = res_pos_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    value_next      = s_tdata;
                    res_status_next = STATUS_OK;
                    res_data_next   = '0;
                    res_pos_next    = '0;
                    state_next      = S_RESULT;
                    unique case (s_tuser)
                        OP_ENQUEUE: begin
                            if (is_full) begin
                                res_status_next = STATUS_FULL;
                            end else begin
                                tail_next  = next_slot(tail_reg);
                                count_next = count_reg + count_t'(1);
                            end
                        end
                        OP_DEQUEUE: begin
                            if (is_empty) begin
                                res_status_next = STATUS_EMPTY;
                            end else begin
                                state_next = S_READ;
                            end
                        end
                        OP_SEARCH: begin
                            if (is_empty) begin
                                res_status_next = STATUS_EMPTY;
                            end else begin
                                scan_next   = next_slot(head_reg);
                                offset_next = '0;
                                state_next  = S_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                res_data_next = ram_rdata;
                head_next     = next_slot(head_reg);
                count_next    = count_reg - count_t'(1);
                state_next    = S_RESULT;
            end
            S_SEARCH: begin
                if (match) begin
                    res_pos_next = offset_reg;
                    state_next   = S_RESULT;
                end else if (last_offset) begin
                    res_status_next = STATUS_MISSING;
                    state_next      = S_RESULT;
                end else begin
                    offset_next = offset_reg + slot_t'(1);
                    scan_next   = next_slot(scan_reg);
                end
            end
            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, occ_ext[3:0], pos_ext[2:0], res_data_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        scan_reg       <= scan_next;
        offset_reg     <= offset_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_pos_reg    <= res_pos_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule
